>>> src/kab_pkg.sv
`timescale 1ns / 1ps
package kab_pkg;
    localparam int AXES = 2;
    localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;

    // register indexes
    localparam logic [1:0] REG_ANGLE_NOISE   = 2'd0;
    localparam logic [1:0] REG_BIAS_NOISE    = 2'd1;
    localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;
    localparam logic [1:0] REG_TIME_STEP     = 2'd3;

    localparam logic [30:0] ANGLE_NOISE_RST   = 31'd2684355;
    localparam logic [30:0] BIAS_NOISE_RST    = 31'd80531;
    localparam logic [30:0] MEASURE_NOISE_RST = 31'd2684355;
    localparam logic [15:0] TIME_STEP_RST     = 16'd13107;

    typedef struct packed {
        logic        axis;
        logic [31:0] acc_angle;
        logic [31:0] gyro_rate;
    } in_beat_t;

    typedef struct packed {
        logic        axis_out;
        logic [31:0] angle_est;
        logic [31:0] bias_est;
    } out_beat_t;

    // clamp a wide signed value to 32 bits
    function automatic logic [31:0] sat32(input logic signed [79:0] x);
        if (x > 80'sh7FFFFFFF) return 32'h7FFFFFFF;
        if (x < -80'sh80000000) return 32'h80000000;
        return x[31:0];
    endfunction
endpackage

>>> src/kalman_angle_bias_filter_top.sv
`timescale 1ns / 1ps
// Two-state Kalman filter (angle, gyro bias) for AXES axes in fixed point.
// An input beat names an axis and gives an accelerometer angle and a gyro
// rate (Q16.16); one result beat returns the new angle and bias estimates.
// Multiplications run through one shared 34x34 multiplier and divisions
// through a radix-2 restoring divider under a sequencer. A beat takes five
// predict multiply steps, two gain divisions (60 quotient bits each), six
// correction multiply steps and a write-back state. The input side is
// stalled while a beat is in work and while the result waits in its output
// register, so the next input beat is taken only after the previous result
// beat has been accepted. Per-axis state resets to zero at once; no
// clearing pass.
module kalman_angle_bias_filter_top
    import kab_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_beat_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_beat_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [31:0] cfg_data
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_OUT  = 4'd3;

    logic [30:0] an_reg, bn_reg, mn_reg;
    logic [15:0] dt_reg;
    logic [31:0] ang_reg [AXES], bia_reg [AXES];
    logic [31:0] p00s_reg [AXES], p01s_reg [AXES], p10s_reg [AXES], p11s_reg [AXES];

    logic [3:0]  st_reg;
    logic [3:0]  op_reg;
    logic [5:0]  cnt_reg;
    logic        gsel_reg;
    logic        ax_reg;
    logic        oob_reg;
    logic signed [31:0] acc_reg, rate_reg;
    logic signed [31:0] a_reg, b_reg, p00_reg, p01_reg, p10_reg, p11_reg, y_reg;
    logic signed [34:0] p00w_reg;
    logic signed [31:0] k0_reg, k1_reg;
    logic signed [31:0] na_reg, nb_reg, n00_reg, n01_reg, n10_reg, n11_reg;
    logic signed [33:0] s_reg;
    // divider: magnitude of dividend, remainder, quotient
    logic [59:0] dvd_reg;
    logic [33:0] rem_reg;
    logic [59:0] quo_reg;
    logic        neg_reg;
    logic        out_valid_reg;
    out_beat_t   out_reg;

    logic [AXW-1:0] ix;
    assign ix = ax_reg;

    // shared multiplier operands chosen by step
    logic signed [33:0] ma, mb;
    logic signed [67:0] prod;
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (op_reg)
            4'd0: begin ma = {18'd0, dt_reg}; mb = 34'(rate_reg) - 34'(b_reg); end
            4'd1: begin ma = {18'd0, dt_reg};
                        mb = 34'(signed'(p10s_reg[ix])) + 34'(signed'(p01s_reg[ix])); end
            4'd2: begin ma = {18'd0, dt_reg}; mb = {3'd0, an_reg}; end
            4'd3: begin ma = {18'd0, dt_reg}; mb = 34'(signed'(p11s_reg[ix])); end
            4'd4: begin ma = {18'd0, dt_reg}; mb = {3'd0, bn_reg}; end
            4'd5: begin ma = 34'(k0_reg); mb = 34'(y_reg); end
            4'd6: begin ma = 34'(k1_reg); mb = 34'(y_reg); end
            4'd7: begin ma = 34'(k0_reg); mb = 34'(p00_reg); end
            4'd8: begin ma = 34'(k0_reg); mb = 34'(p01_reg); end
            4'd9: begin ma = 34'(k1_reg); mb = 34'(p00_reg); end
            4'd10: begin ma = 34'(k1_reg); mb = 34'(p01_reg); end
            default: ;
        endcase
        prod = ma * mb;
    end

    logic signed [79:0] r16, r28;
    assign r16 = (80'(prod) + 80'sd32768) >>> 16;
    assign r28 = (80'(prod) + 80'sd134217728) >>> 28;

    logic [34:0] trial;
    assign trial = {rem_reg, dvd_reg[59]} - {1'b0, s_reg[33:0]};

    assign in_stall  = (st_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            an_reg <= ANGLE_NOISE_RST;
            bn_reg <= BIAS_NOISE_RST;
            mn_reg <= MEASURE_NOISE_RST;
            dt_reg <= TIME_STEP_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ANGLE_NOISE:   an_reg <= cfg_data[30:0];
                REG_BIAS_NOISE:    bn_reg <= cfg_data[30:0];
                REG_MEASURE_NOISE: mn_reg <= cfg_data[30:0];
                REG_TIME_STEP:     dt_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sequencer and shared datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            op_reg <= '0;
            cnt_reg <= '0;
            gsel_reg <= 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                ang_reg[i] <= '0; bia_reg[i] <= '0;
                p00s_reg[i] <= '0; p01s_reg[i] <= '0;
                p10s_reg[i] <= '0; p11s_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        ax_reg   <= in_data.axis;
                        oob_reg  <= (32'(in_data.axis) >= AXES);
                        acc_reg  <= in_data.acc_angle;
                        rate_reg <= in_data.gyro_rate;
                        b_reg    <= bia_reg[AXW'(in_data.axis)];
                        op_reg   <= 4'd0;
                        st_reg   <= (32'(in_data.axis) >= AXES) ? S_OUT : S_MUL;
                    end
                end
                S_MUL:
                begin
                    op_reg <= op_reg + 4'd1;
                    case (op_reg)
                        4'd0: a_reg <= sat32(80'(signed'(ang_reg[ix])) + r16);
                        // keep the partial P00 wide; saturate once with the noise term
                        4'd1: p00w_reg <= 35'(80'(signed'(p00s_reg[ix])) - r16);
                        4'd2: begin
                            p00_reg <= sat32(80'(p00w_reg) + r16);
                            y_reg <= sat32(80'(acc_reg) - 80'(a_reg));
                        end
                        4'd3: begin
                            p01_reg <= sat32(80'(signed'(p01s_reg[ix])) - r16);
                            p10_reg <= sat32(80'(signed'(p10s_reg[ix])) - r16);
                            s_reg <= 34'(p00_reg) + 34'(mn_reg);
                        end
                        4'd4: begin
                            p11_reg <= sat32(80'(signed'(p11s_reg[ix])) + r16);
                            // start gain 0 division
                            gsel_reg <= 1'b0;
                            neg_reg <= p00_reg[31];
                            dvd_reg <= {(p00_reg[31] ? 32'(-33'(p00_reg)) : 32'(p00_reg)),
                                        28'd0};
                            rem_reg <= '0;
                            quo_reg <= '0;
                            cnt_reg <= '0;
                            st_reg <= S_DIV;
                        end
                        4'd5: na_reg  <= sat32(80'(a_reg) + r28);
                        4'd6: nb_reg  <= sat32(80'(b_reg) + r28);
                        4'd7: n00_reg <= sat32(80'(p00_reg) - r28);
                        4'd8: n01_reg <= sat32(80'(p01_reg) - r28);
                        4'd9: n10_reg <= sat32(80'(p10_reg) - r28);
                        4'd10:
                        begin
                            n11_reg <= sat32(80'(p11_reg) - r28);
                            st_reg <= S_OUT;
                        end
                        default: st_reg <= S_OUT;
                    endcase
                end
                S_DIV:
                begin
                    // one restoring quotient bit per cycle
                    dvd_reg <= {dvd_reg[58:0], 1'b0};
                    if (!trial[34])
                    begin
                        rem_reg <= trial[33:0];
                        quo_reg <= {quo_reg[58:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[32:0], dvd_reg[59]};
                        quo_reg <= {quo_reg[58:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd60)
                    begin
                        // quo_reg now holds the full quotient; rem shifts are spent
                        logic signed [79:0] q;
                        logic [31:0] k;
                        q = neg_reg ? -80'(quo_reg) : 80'(quo_reg);
                        k = (s_reg <= 0) ? 32'd0 : sat32(q);
                        if (!gsel_reg)
                        begin
                            k0_reg <= k;
                            gsel_reg <= 1'b1;
                            neg_reg <= p10_reg[31];
                            dvd_reg <= {(p10_reg[31] ? 32'(-33'(p10_reg)) : 32'(p10_reg)),
                                        28'd0};
                            rem_reg <= '0;
                            quo_reg <= '0;
                            cnt_reg <= '0;
                        end
                        else
                        begin
                            k1_reg <= k;
                            op_reg <= 4'd5;
                            st_reg <= S_MUL;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg.axis_out <= ax_reg;
                        out_reg.angle_est <= oob_reg ? 32'd0 : na_reg;
                        out_reg.bias_est  <= oob_reg ? 32'd0 : nb_reg;
                        if (!oob_reg)
                        begin
                            ang_reg[ix]  <= na_reg;
                            bia_reg[ix]  <= nb_reg;
                            p00s_reg[ix] <= n00_reg;
                            p01s_reg[ix] <= n01_reg;
                            p10s_reg[ix] <= n10_reg;
                            p11s_reg[ix] <= n11_reg;
                        end
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> verif/kab_checker.sv
`timescale 1ns / 1ps
module kab_checker
    import kab_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  in_beat_t    in_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  out_beat_t   out_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    // filter settings and per-axis state
    logic [30:0] q_angle, q_bias, r_meas;
    logic [15:0] dt;
    logic signed [31:0] st_angle [AXES];
    logic signed [31:0] st_bias [AXES];
    logic signed [31:0] p_aa [AXES];
    logic signed [31:0] p_ab [AXES];
    logic signed [31:0] p_ba [AXES];
    logic signed [31:0] p_bb [AXES];
    out_beat_t estimates [$];

    function automatic logic signed [31:0] clamp(input logic signed [127:0] x);
        if (x > 128'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (x < -128'sh80000000) return 32'sh80000000;
        return x[31:0];
    endfunction

    // round half up, then floor shift
    function automatic logic signed [127:0] round_shift(input logic signed [127:0] x,
                                                        input int s);
        logic signed [127:0] t;
        t = x + (128'sd1 <<< (s - 1));
        return t >>> s;
    endfunction

    function automatic logic signed [31:0] kalman_gain(input logic signed [31:0] p,
                                                       input logic signed [127:0] s);
        logic signed [127:0] num;
        num = 128'(p) <<< 28;
        if (s <= 0) return 32'sd0;
        return clamp(num / s);
    endfunction

    task automatic update_axis(input in_beat_t b);
        logic signed [127:0] d, acc, rate, s;
        logic signed [31:0] a, bb, p00, p01, p10, p11, y, k0, k1;
        int i;
        out_beat_t r;
        d = 128'(dt);
        acc = 128'($signed(b.acc_angle));
        rate = 128'($signed(b.gyro_rate));
        r.axis_out = b.axis;
        r.angle_est = '0;
        r.bias_est = '0;
        i = int'(b.axis);
        if (i < AXES)
        begin
            a = clamp(128'(st_angle[i]) + round_shift(d * (rate - 128'(st_bias[i])), 16));
            bb = st_bias[i];
            p00 = clamp(128'(p_aa[i]) - round_shift(d * (128'(p_ba[i]) + 128'(p_ab[i])), 16)
                        + round_shift(128'(q_angle) * d, 16));
            p01 = clamp(128'(p_ab[i]) - round_shift(d * 128'(p_bb[i]), 16));
            p10 = clamp(128'(p_ba[i]) - round_shift(d * 128'(p_bb[i]), 16));
            p11 = clamp(128'(p_bb[i]) + round_shift(128'(q_bias) * d, 16));
            y = clamp(acc - 128'(a));
            s = 128'(p00) + 128'(r_meas);
            k0 = kalman_gain(p00, s);
            k1 = kalman_gain(p10, s);
            st_angle[i] = clamp(128'(a) + round_shift(128'(k0) * 128'(y), 28));
            st_bias[i] = clamp(128'(bb) + round_shift(128'(k1) * 128'(y), 28));
            p_aa[i] = clamp(128'(p00) - round_shift(128'(k0) * 128'(p00), 28));
            p_ab[i] = clamp(128'(p01) - round_shift(128'(k0) * 128'(p01), 28));
            p_ba[i] = clamp(128'(p10) - round_shift(128'(k1) * 128'(p00), 28));
            p_bb[i] = clamp(128'(p11) - round_shift(128'(k1) * 128'(p01), 28));
            r.angle_est = st_angle[i];
            r.bias_est = st_bias[i];
        end
        estimates.push_back(r);
    endtask

    assign pending = estimates.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t e;
        if (!rst_n)
        begin
            q_angle = ANGLE_NOISE_RST;
            q_bias = BIAS_NOISE_RST;
            r_meas = MEASURE_NOISE_RST;
            dt = TIME_STEP_RST;
            for (int k = 0; k < AXES; k++)
            begin
                st_angle[k] = 0; st_bias[k] = 0;
                p_aa[k] = 0; p_ab[k] = 0; p_ba[k] = 0; p_bb[k] = 0;
            end
            estimates.delete();
            fail_count = 0;
        end
        else
        begin
            // track register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ANGLE_NOISE:   q_angle = cfg_data[30:0];
                    REG_BIAS_NOISE:    q_bias = cfg_data[30:0];
                    REG_MEASURE_NOISE: r_meas = cfg_data[30:0];
                    REG_TIME_STEP:     dt = cfg_data[15:0];
                    default: ;
                endcase
            end
            // compare result beat with oldest estimate
            if (out_valid && !out_stall)
            begin
                if (estimates.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat %h", out_data);
                end
                else
                begin
                    e = estimates.pop_front();
                    if (e.axis_out !== out_data.axis_out || e.angle_est !== out_data.angle_est
                        || e.bias_est !== out_data.bias_est)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp axis %0d angle %h bias %h, got %0d %h %h",
                                     e.axis_out, e.angle_est, e.bias_est, out_data.axis_out,
                                     out_data.angle_est, out_data.bias_est);
                    end
                end
            end
            // predict accepted input beat
            if (in_valid && !in_stall)
                update_axis(in_data);
        end
    end
endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import kab_pkg::*;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
    in_beat_t in_data;
    out_beat_t out_data;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;
    int fail_count, pending;
    int cycles;
    bit hold_off;

    kalman_angle_bias_filter_top u_top (.*);

    kab_checker u_chk (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 3000000)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // receiver: random stall per beat, one long hold-off
    initial
    begin
        int w;
        bit held;
        held = 0;
        out_stall = 1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off && !held)
            begin
                out_stall <= 1;
                repeat (600) @(negedge clk);
                held = 1;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (w > 0)
            begin
                out_stall <= 1;
                repeat (w - 1) @(negedge clk);
                @(negedge clk);
            end
            out_stall <= 0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic send_sample(input logic ax, input logic [31:0] acc, input logic [31:0] rate,
                               input bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 19) : 0;
        repeat (w) @(negedge clk);
        in_data = '{axis: ax, acc_angle: acc, gyro_rate: rate};
        in_valid = 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    function automatic logic [31:0] angle_value();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return {$urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000};
            default: return $signed($urandom_range(0, 12000000)) - 32'sd6000000;
        endcase
    endfunction

    initial
    begin
        logic [31:0] edge_vals [6];
        int ph;
        edge_vals = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h1, 32'h00010000};
        rst_n = 0; in_valid = 0; cfg_valid = 0; hold_off = 0;
        in_data = '0; cfg_index = '0; cfg_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: field extremes on both axes at reset settings
        for (int k = 0; k < 12; k++)
            send_sample(k[0], edge_vals[k % 6], edge_vals[(k + 3) % 6], 0);
        drain();
        // extreme settings: max noise with max dt saturates, then zero noise
        write_reg(REG_ANGLE_NOISE, 32'h7FFFFFFF);
        write_reg(REG_BIAS_NOISE, 32'h7FFFFFFF);
        write_reg(REG_MEASURE_NOISE, 32'h1);
        write_reg(REG_TIME_STEP, 32'hFFFF);
        for (int k = 0; k < 6; k++)
            send_sample(k[0], edge_vals[k], edge_vals[5 - k], 0);
        drain();
        write_reg(REG_ANGLE_NOISE, 32'h0);
        write_reg(REG_BIAS_NOISE, 32'h0);
        write_reg(REG_MEASURE_NOISE, 32'h7FFFFFFF);
        write_reg(REG_TIME_STEP, 32'h1);
        for (int k = 0; k < 6; k++)
            send_sample(k[0], edge_vals[5 - k], edge_vals[k], 0);
        drain();

        // random phases with new settings between them
        for (ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_ANGLE_NOISE, (ph == 5) ? 32'd2684355 : $urandom());
            write_reg(REG_BIAS_NOISE, $urandom_range(0, 1000000));
            write_reg(REG_MEASURE_NOISE, $urandom_range(1, 32'h7FFFFFFF) | (ph[0] << 31));
            write_reg(REG_TIME_STEP, $urandom_range(1, 65535));
            if (ph == 2)
                hold_off = 1;
            for (int k = 0; k < 255; k++)
                send_sample($urandom_range(0, 1), angle_value(), angle_value(), k % 40 > 8);
            drain();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

>>> files.f
src/kab_pkg.sv
src/kalman_angle_bias_filter_top.sv
verif/kab_checker.sv
verif/testbench.sv
